[sv/multi_source_key_autorepeat_assert.svh]
// ----------------------------------------------------------------------------
// multi_source_key_autorepeat_assert.svh
// assertion macros for the key auto-repeat modules, used by msk_ctrl
// ----------------------------------------------------------------------------
`ifndef MULTI_SOURCE_KEY_AUTOREPEAT_ASSERT_SVH
`define MULTI_SOURCE_KEY_AUTOREPEAT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MSK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define MSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/msk_pkg.sv]
// ----------------------------------------------------------------------------
// msk_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package msk_pkg;

  localparam int MaxSources = 16;
  localparam int SlotW      = $clog2(MaxSources);
  localparam int KeySpace   = 256;
  localparam int KeyW       = 8;
  localparam int SrcW       = 32;
  localparam int HoldW      = 9;
  localparam int CntW       = HoldW + 1;
  localparam int CfgW       = 8;
  localparam int CfgIdxW    = 2;
  localparam int IdxW       = KeyW;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEasyMode       = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRepeatDelay    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIntervalNormal = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIntervalEasy   = 2'd3;

  // configuration reset values
  localparam logic [CfgW-1:0] DelayRst       = 8'd30;
  localparam logic [CfgW-1:0] IntervalNrmRst = 8'd2;
  localparam logic [CfgW-1:0] IntervalEsyRst = 8'd10;

  typedef struct packed {
    logic latch;
    logic scan;
    logic apply;
    logic tick;
    logic rall;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic op_tick;
    logic src_zero;
    logic is_down;
    logic slot_last;
    logic key_last;
  } sts_t;

endpackage

[sv/msk_ctrl.sv]
// ----------------------------------------------------------------------------
// msk_ctrl
// sequencer: decodes the captured transaction and walks slots or keys
// ----------------------------------------------------------------------------
module msk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output msk_pkg::cmd_t cmd_o,
  input  msk_pkg::sts_t sts_i
);
  import msk_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    DISPATCH,
    SCAN,
    APPLY,
    TICK,
    RALL,
    FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      IDLE: begin
        cmd_o.latch = start;
        if (start) state_d = DISPATCH;
      end
      DISPATCH: begin
        if (sts_i.op_tick) state_d = TICK;
        else if (sts_i.src_zero) state_d = sts_i.is_down ? FLUSH : RALL;
        else state_d = SCAN;
      end
      SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.slot_last) state_d = APPLY;
      end
      APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = FLUSH;
      end
      TICK: begin
        cmd_o.tick = 1'b1;
        if (sts_i.slot_last) state_d = FLUSH;
      end
      RALL: begin
        cmd_o.rall = 1'b1;
        if (sts_i.key_last) state_d = FLUSH;
      end
      FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = IDLE;
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != IDLE);
    end
  end

  assign busy = busy_q;

  `include "multi_source_key_autorepeat_assert.svh"

  `MSK_ASSERT_NEXT(a_accept_busy, start && !busy_q, busy_q, "accepted start did not raise busy")
  `MSK_ASSERT_NEXT(a_flush_done, state_q == FLUSH, state_q == IDLE, "flush did not end the transaction")
  `MSK_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0(cmd_o), "more than one datapath command")
  `MSK_ASSERT_NEXT(a_scan_apply, state_q == SCAN && sts_i.slot_last, state_q == APPLY, "scan did not end in apply")

endmodule

[sv/msk_datapath.sv]
// ----------------------------------------------------------------------------
// msk_datapath
// slot table, config registers, walk counter and result staging
// ----------------------------------------------------------------------------
module msk_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  msk_pkg::cmd_t                cmd_i,
  output msk_pkg::sts_t                sts_o,
  input  logic                         cfg_we_i,
  input  logic [msk_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [msk_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         operation_i,
  input  logic [msk_pkg::SrcW-1:0]     source_id_i,
  input  logic                         is_down_i,
  input  logic [msk_pkg::KeyW-1:0]     key_code_i,
  output logic                         result_valid_o,
  output logic [msk_pkg::KeyW-1:0]     out_key_o,
  output logic                         pressed_o,
  output logic                         last_o
);
  import msk_pkg::*;

  // config
  logic            easy_q;
  logic [CfgW-1:0] delay_q, int_nrm_q, int_esy_q;

  // captured transaction
  logic            op_q, down_q;
  logic [SrcW-1:0] src_q;
  logic [KeyW-1:0] key_q;

  // slot table
  logic [MaxSources-1:0] slot_valid_q;
  logic [SrcW-1:0]       slot_src_q  [MaxSources];
  logic [KeyW-1:0]       slot_key_q  [MaxSources];
  logic [HoldW-1:0]      slot_hold_q [MaxSources];
  logic [MaxSources-1:0] slot_sup_q;

  // walk and scan results
  logic [IdxW-1:0]  idx_q;
  logic             found_vld_q, free_vld_q, keyheld_q;
  logic [SlotW-1:0] found_idx_q, free_idx_q;

  // result staging
  logic            pend_vld_q, pend_prs_q;
  logic [KeyW-1:0] pend_key_q;
  logic            out_vld_q, out_prs_q, out_last_q;
  logic [KeyW-1:0] out_key_q;

  logic [SlotW-1:0] sel;
  logic             sel_valid, sel_sup;
  logic [SrcW-1:0]  sel_src;
  logic [KeyW-1:0]  sel_key;
  logic [HoldW-1:0] sel_hold;
  logic [CfgW-1:0]  ivl, ivl_eff;
  logic [CntW-1:0]  cnt, dly_c, ivl_c, phase, hold_new;
  logic             below, tick_active, tick_emit;
  logic             key_present, others, key_ok, press_take;
  logic [KeyW-1:0]  fnd_key;
  logic             emit_en, emit_prs;
  logic [KeyW-1:0]  emit_key;

  assign sel       = idx_q[SlotW-1:0];
  assign sel_valid = slot_valid_q[sel];
  assign sel_sup   = slot_sup_q[sel];
  assign sel_src   = slot_src_q[sel];
  assign sel_key   = slot_key_q[sel];
  assign sel_hold  = slot_hold_q[sel];

  assign sts_o.op_tick   = op_q;
  assign sts_o.src_zero  = (src_q == '0);
  assign sts_o.is_down   = down_q;
  assign sts_o.slot_last = (sel == SlotW'(MaxSources - 1));
  assign sts_o.key_last  = (idx_q == IdxW'(KeySpace - 1));

  // hold counter step
  assign ivl         = easy_q ? int_esy_q : int_nrm_q;
  assign ivl_eff     = (ivl == '0) ? CfgW'(1) : ivl;
  assign cnt         = CntW'(sel_hold) + CntW'(1);
  assign dly_c       = CntW'(delay_q);
  assign ivl_c       = CntW'(ivl_eff);
  assign below       = (cnt < dly_c);
  assign phase       = cnt - dly_c;
  assign tick_active = sel_valid && !sel_sup;
  assign tick_emit   = tick_active && !below && ((phase == '0) || (phase >= ivl_c));
  assign hold_new    = (!below && (phase != '0) && (phase >= ivl_c)) ? dly_c : cnt;

  // key presence across the table
  assign fnd_key = slot_key_q[found_idx_q];
  always_comb begin
    key_present = 1'b0;
    others      = 1'b0;
    for (int j = 0; j < MaxSources; j++) begin
      if (slot_valid_q[j] && (slot_key_q[j] == idx_q)) key_present = 1'b1;
      if (slot_valid_q[j] && (slot_key_q[j] == fnd_key) && (SlotW'(j) != found_idx_q))
        others = 1'b1;
    end
  end

  assign key_ok     = (key_q != '0) && ({1'b0, key_q} < (KeyW + 1)'(KeySpace));
  assign press_take = down_q && !found_vld_q && free_vld_q && key_ok;

  always_comb begin
    emit_en  = 1'b0;
    emit_key = key_q;
    emit_prs = 1'b1;
    if (cmd_i.tick) begin
      emit_en  = tick_emit;
      emit_key = sel_key;
    end else if (cmd_i.rall) begin
      emit_en  = key_present;
      emit_key = idx_q;
      emit_prs = 1'b0;
    end else if (cmd_i.apply) begin
      if (down_q) begin
        emit_en = press_take && !keyheld_q;
      end else begin
        emit_en  = found_vld_q && !others;
        emit_key = fnd_key;
        emit_prs = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      easy_q       <= 1'b0;
      delay_q      <= DelayRst;
      int_nrm_q    <= IntervalNrmRst;
      int_esy_q    <= IntervalEsyRst;
      slot_valid_q <= '0;
      idx_q        <= '0;
      found_vld_q  <= 1'b0;
      free_vld_q   <= 1'b0;
      keyheld_q    <= 1'b0;
      pend_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgEasyMode:       easy_q    <= cfg_wdata_i[0];
          CfgRepeatDelay:    delay_q   <= cfg_wdata_i;
          CfgIntervalNormal: int_nrm_q <= cfg_wdata_i;
          CfgIntervalEasy:   int_esy_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (cmd_i.latch) begin
        idx_q       <= '0;
        found_vld_q <= 1'b0;
        free_vld_q  <= 1'b0;
        keyheld_q   <= 1'b0;
      end else if (cmd_i.scan || cmd_i.tick || cmd_i.rall) begin
        idx_q <= idx_q + IdxW'(1);
      end

      if (cmd_i.scan) begin
        if (sel_valid) begin
          if ((sel_src == src_q) && !found_vld_q) found_vld_q <= 1'b1;
          if (sel_key == key_q) keyheld_q <= 1'b1;
        end else if (!free_vld_q) begin
          free_vld_q <= 1'b1;
        end
      end

      if (cmd_i.apply) begin
        if (press_take) slot_valid_q[free_idx_q] <= 1'b1;
        else if (!down_q && found_vld_q) slot_valid_q[found_idx_q] <= 1'b0;
      end

      if (cmd_i.rall && sts_o.key_last) slot_valid_q <= '0;

      // one-deep staging so the final result can carry last
      out_vld_q <= (emit_en || cmd_i.flush) && pend_vld_q;
      if (emit_en) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= operation_i;
      src_q  <= source_id_i;
      down_q <= is_down_i;
      key_q  <= key_code_i;
    end

    if (cmd_i.scan) begin
      if (sel_valid) begin
        if ((sel_src == src_q) && !found_vld_q) found_idx_q <= sel;
      end else if (!free_vld_q) begin
        free_idx_q <= sel;
      end
    end

    if (cmd_i.apply && press_take) begin
      for (int j = 0; j < MaxSources; j++) begin
        if (!easy_q && slot_valid_q[j]) slot_sup_q[j] <= 1'b1;
      end
      slot_src_q[free_idx_q]  <= src_q;
      slot_key_q[free_idx_q]  <= key_q;
      slot_hold_q[free_idx_q] <= '0;
      slot_sup_q[free_idx_q]  <= 1'b0;
    end

    if (cmd_i.tick && tick_active && below) slot_hold_q[sel] <= hold_new[HoldW-1:0];
    else if (cmd_i.tick && tick_active) slot_hold_q[sel] <= hold_new[HoldW-1:0];

    if (emit_en) begin
      pend_key_q <= emit_key;
      pend_prs_q <= emit_prs;
      out_key_q  <= pend_key_q;
      out_prs_q  <= pend_prs_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.flush) begin
      out_key_q  <= pend_key_q;
      out_prs_q  <= pend_prs_q;
      out_last_q <= 1'b1;
    end
  end

  assign result_valid_o = out_vld_q;
  assign out_key_o      = out_key_q;
  assign pressed_o      = out_prs_q;
  assign last_o         = out_last_q;

endmodule

[sv/multi_source_key_autorepeat.sv]
// ----------------------------------------------------------------------------
// multi_source_key_autorepeat
// merges key events from many sources into key press/release events with
// typematic auto-repeat
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  command   | start, busy            | operation_i source_id_i is_down_i
//            |                        | key_code_i
//  result    | result_valid_o strobe  | out_key_o pressed_o last_o
//  config    | cfg_we_i               | cfg_index_i cfg_wdata_i
//
//  a tick walks the 16 slots one per cycle
//  a source event scans the slots for the source and a free slot
//  a release from source zero walks all 256 key codes
//  a press from source zero is dropped
//  reset clears the slot valid bits at once; no clearing pass
//  each result is held back one stage and leaves when the next one is found
//  or at flush; results cannot be stalled, and the final one of a
//  transaction shows in the same cycle that busy falls
// ----------------------------------------------------------------------------
module multi_source_key_autorepeat (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command transaction
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic [msk_pkg::SrcW-1:0]     source_id_i,
  input  logic                         is_down_i,
  input  logic [msk_pkg::KeyW-1:0]     key_code_i,
  // result transactions
  output logic                         result_valid_o,
  output logic [msk_pkg::KeyW-1:0]     out_key_o,
  output logic                         pressed_o,
  output logic                         last_o,
  // config writes
  input  logic                         cfg_we_i,
  input  logic [msk_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [msk_pkg::CfgW-1:0]     cfg_wdata_i
);
  import msk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  msk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // slot table, config and result staging
  msk_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .source_id_i    (source_id_i),
    .is_down_i      (is_down_i),
    .key_code_i     (key_code_i),
    .result_valid_o (result_valid_o),
    .out_key_o      (out_key_o),
    .pressed_o      (pressed_o),
    .last_o         (last_o)
  );

endmodule
